// ----- sv/gnp_pkg.sv -----
`timescale 1ns / 1ps
package gnp_pkg;
    localparam int MaxNodes = 128;
    localparam int MaxEdges = 256;
    localparam int NodeIdBits = 7;
    localparam int EdgeIdBits = 8;

    typedef enum logic [3:0] {
        OP_CLEAR    = 4'd0,
        OP_ADD_NODE = 4'd1,
        OP_ADD_EDGE = 4'd2,
        OP_CLICK    = 4'd3,
        OP_HOVER    = 4'd4,
        OP_DELETE   = 4'd5,
        OP_UNSELECT = 4'd6,
        OP_READ_NODE = 4'd7,
        OP_READ_EDGE = 4'd8
    } opcode_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_EDGE = 2'd3;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_z;
        logic [14:0]        radius;
        logic [6:0]         node_a;
        logic [6:0]         node_b;
        logic [7:0]         edge_index;
    } gnp_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         id_out;
        logic               selected_valid;
        logic [6:0]         selected_id;
        logic               hover_valid;
        logic [6:0]         hover_id;
        logic [32:0]        distance_sq;
        logic signed [15:0] out_x;
        logic signed [15:0] out_z;
        logic [14:0]        out_radius;
        logic               alive_out;
        logic [6:0]         other_id;
    } gnp_out_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_NSCAN, S_NDRAIN, S_NSQ, S_NCMP, S_HITRD, S_HITCHK,
        S_ESCAN, S_ERD, S_OUT
    } gnp_state_t;
endpackage

// ----- sv/graph_node_picker.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Ports                     | Payload
// input   | in        | s_valid, s_ready, s_data  | gnp_in_t
// result  | out       | m_valid, m_ready, m_data  | gnp_out_t
//
// One transaction is processed at a time. Click and hover stream the node
// memory one entry per cycle through a distance pipeline. Delete sweeps the
// edge memory one entry per cycle. Reset (aresetn, synchronous, active low)
// clears the counts and selections; the memories are not cleared, as only
// entries below the counts are read. The result sits in an output register
// until taken, while the next transaction is already accepted and worked on;
// only when that one has finished too does the block wait for the output
// register to free up.
module graph_node_picker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gnp_pkg::gnp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gnp_pkg::gnp_out_t m_data
);
    import gnp_pkg::*;

    // Node memory: {x, z, radius, alive}; edge memory: {a, b, alive}.
    logic [47:0] node_mem [MaxNodes];
    logic [14:0] edge_mem [MaxEdges];

    gnp_state_t state_reg, state_next;
    gnp_in_t    in_reg;
    gnp_out_t   out_reg;
    gnp_out_t   res_reg;
    gnp_out_t   out_word;
    logic       mv_reg;
    logic [7:0] ncount_reg;
    logic [8:0] ecount_reg;
    logic       selv_reg, hovv_reg;
    logic [6:0] seli_reg, hovi_reg;

    // Scan pipeline.
    logic [8:0]  scan_reg;         // address counter
    logic        p1v_reg, p2v_reg;
    logic [6:0]  p1i_reg, p2i_reg;
    logic [47:0] nrd_reg;
    logic [15:0] dx_reg, dz_reg;
    logic [32:0] d2_reg;
    logic        found_reg;
    logic [6:0]  best_reg;
    logic [32:0] bestd_reg;
    logic [29:0] rsq_reg;
    logic [14:0] erd_reg;
    logic        e1v_reg;
    logic [7:0]  e1i_reg;

    logic signed [16:0] dx_diff, dz_diff;
    logic [15:0] dx_mag, dz_mag;
    logic [31:0] dx_sq, dz_sq;

    logic [47:0] node_wdata;
    logic        node_we;
    logic [6:0]  node_waddr, node_raddr;
    logic        edge_we;
    logic [7:0]  edge_waddr, edge_raddr;
    logic [14:0] edge_wdata;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_valid) state_next = S_DISPATCH;
            S_DISPATCH: begin
                if (in_reg.opcode == OP_CLICK || in_reg.opcode == OP_HOVER)
                    state_next = S_NSCAN;
                else if (in_reg.opcode == OP_DELETE && selv_reg)
                    state_next = S_ESCAN;
                else if (in_reg.opcode == OP_READ_NODE || in_reg.opcode == OP_READ_EDGE)
                    state_next = S_HITRD;
                else
                    state_next = S_OUT;
            end
            S_NSCAN:  if (scan_reg >= {1'b0, ncount_reg}) state_next = S_NDRAIN;
            S_NDRAIN: state_next = S_NSQ;
            S_NSQ:    state_next = S_NCMP;
            S_NCMP:   state_next = S_HITRD;
            S_HITRD:  state_next = S_HITCHK;
            S_HITCHK: state_next = S_OUT;
            S_ESCAN:  if (scan_reg >= ecount_reg) state_next = S_ERD;
            S_ERD:    state_next = S_OUT;
            S_OUT:    if (!mv_reg || m_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = res_reg;

    // Result word with the selections as they stand after the transaction.
    always_comb begin
        out_word = out_reg;
        out_word.selected_valid = selv_reg;
        out_word.selected_id = seli_reg;
        out_word.hover_valid = hovv_reg;
        out_word.hover_id = hovi_reg;
    end

    // Read address selection. While idle the selected node is read, so that
    // a delete can clear its alive bit and keep the rest of the word.
    always_comb begin
        node_raddr = scan_reg[6:0];
        edge_raddr = scan_reg[7:0];
        if (state_reg == S_IDLE) node_raddr = seli_reg;
        if (state_reg == S_NCMP || state_reg == S_HITRD) node_raddr = best_reg;
        if (state_reg == S_DISPATCH || state_reg == S_HITRD) begin
            if (in_reg.opcode == OP_READ_NODE) node_raddr = in_reg.node_a;
            edge_raddr = in_reg.edge_index;
        end
    end

    always_ff @(posedge aclk) begin
        nrd_reg <= node_mem[node_raddr];
        erd_reg <= edge_mem[edge_raddr];
        if (node_we) node_mem[node_waddr] <= node_wdata;
        if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    end

    // Absolute coordinate differences and their squares.
    always_comb begin
        dx_diff = $signed({nrd_reg[47], nrd_reg[47:32]})
                  - $signed({in_reg.pos_x[15], in_reg.pos_x});
        dz_diff = $signed({nrd_reg[31], nrd_reg[31:16]})
                  - $signed({in_reg.pos_z[15], in_reg.pos_z});
        dx_mag = 16'(dx_diff[16] ? -dx_diff : dx_diff);
        dz_mag = 16'(dz_diff[16] ? -dz_diff : dz_diff);
        dx_sq = {16'b0, dx_reg} * {16'b0, dx_reg};
        dz_sq = {16'b0, dz_reg} * {16'b0, dz_reg};
    end

    logic hit;
    always_comb begin
        hit = found_reg && ({3'b0, rsq_reg} >= bestd_reg);
        node_we = 1'b0; node_waddr = ncount_reg[6:0];
        node_wdata = {in_reg.pos_x, in_reg.pos_z, in_reg.radius, 1'b1};
        edge_we = 1'b0; edge_waddr = ecount_reg[7:0];
        edge_wdata = {in_reg.node_a, in_reg.node_b, 1'b1};
        if (state_reg == S_DISPATCH) begin
            if (in_reg.opcode == OP_ADD_NODE && ncount_reg < 8'(MaxNodes))
                node_we = 1'b1;
            if (in_reg.opcode == OP_ADD_EDGE && ecount_reg < 9'(MaxEdges))
                edge_we = 1'b1;
            if (in_reg.opcode == OP_DELETE && selv_reg) begin
                node_we = 1'b1; node_waddr = seli_reg;
                node_wdata = {nrd_reg[47:1], 1'b0};
            end
        end
        if (state_reg == S_HITCHK && in_reg.opcode == OP_CLICK && hit && selv_reg
            && seli_reg != best_reg && ecount_reg < 9'(MaxEdges)) begin
            edge_we = 1'b1; edge_wdata = {seli_reg, best_reg, 1'b1};
        end
        if ((state_reg == S_ESCAN || state_reg == S_ERD) && e1v_reg && erd_reg[0]
            && (erd_reg[14:8] == seli_reg || erd_reg[7:1] == seli_reg)) begin
            edge_we = 1'b1; edge_waddr = e1i_reg; edge_wdata = {erd_reg[14:1], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; mv_reg <= 1'b0;
            ncount_reg <= '0; ecount_reg <= '0;
            selv_reg <= 1'b0; seli_reg <= '0; hovv_reg <= 1'b0; hovi_reg <= '0;
            p1v_reg <= 1'b0; p2v_reg <= 1'b0; e1v_reg <= 1'b0; found_reg <= 1'b0;
            scan_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            if (state_reg == S_OUT && (!mv_reg || m_ready)) begin
                mv_reg <= 1'b1;
                res_reg <= out_word;
            end
            p1v_reg <= 1'b0; p2v_reg <= 1'b0; e1v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    scan_reg <= '0; found_reg <= 1'b0;
                    if (s_valid) begin
                        in_reg <= s_data;
                        out_reg <= '0;
                    end
                end
                S_DISPATCH: begin
                    unique case (in_reg.opcode)
                        OP_CLEAR: begin
                            ncount_reg <= '0; ecount_reg <= '0;
                            selv_reg <= 1'b0; seli_reg <= '0;
                            hovv_reg <= 1'b0; hovi_reg <= '0;
                        end
                        OP_ADD_NODE: begin
                            if (ncount_reg < 8'(MaxNodes)) begin
                                out_reg.id_out <= ncount_reg;
                                ncount_reg <= ncount_reg + 8'd1;
                            end else out_reg.status <= ST_FULL;
                        end
                        OP_ADD_EDGE: begin
                            if (ecount_reg < 9'(MaxEdges)) begin
                                out_reg.id_out <= ecount_reg[7:0];
                                ecount_reg <= ecount_reg + 9'd1;
                            end else out_reg.status <= ST_FULL;
                        end
                        OP_DELETE: begin
                            if (!selv_reg) out_reg.status <= ST_MISS;
                            else out_reg.id_out <= {1'b0, seli_reg};
                        end
                        OP_UNSELECT: selv_reg <= 1'b0;
                        default: ;
                    endcase
                end
                S_NSCAN: begin
                    if (scan_reg < {1'b0, ncount_reg}) begin
                        p1v_reg <= 1'b1; p1i_reg <= scan_reg[6:0];
                        scan_reg <= scan_reg + 9'd1;
                    end
                end
                default: ;
            endcase
            // Distance pipeline: memory read, differences, squares, compare.
            if (state_reg == S_NSCAN || state_reg == S_NDRAIN) begin
                p2v_reg <= p1v_reg && nrd_reg[0];
                p2i_reg <= p1i_reg;
                dx_reg <= dx_mag;
                dz_reg <= dz_mag;
            end
            if (state_reg == S_NSCAN || state_reg == S_NDRAIN || state_reg == S_NSQ) begin
                d2_reg <= {1'b0, dx_sq} + {1'b0, dz_sq};
                e1v_reg <= p2v_reg; e1i_reg <= {1'b0, p2i_reg};
            end
            if ((state_reg == S_NDRAIN || state_reg == S_NSQ || state_reg == S_NCMP
                 || state_reg == S_NSCAN) && e1v_reg && e1i_reg[7] == 1'b0
                 && state_reg != S_ESCAN) begin
                if (!found_reg || d2_reg < bestd_reg) begin
                    found_reg <= 1'b1; bestd_reg <= d2_reg; best_reg <= e1i_reg[6:0];
                end
            end
            if (state_reg == S_HITRD) begin
                if (in_reg.opcode == OP_READ_NODE) begin
                    out_reg.id_out <= {1'b0, in_reg.node_a};
                    if ({1'b0, in_reg.node_a} < ncount_reg) begin
                        out_reg.out_x <= nrd_reg[47:32];
                        out_reg.out_z <= nrd_reg[31:16];
                        out_reg.alive_out <= nrd_reg[0];
                        out_reg.out_radius <= nrd_reg[0] ? nrd_reg[15:1] : '0;
                    end
                end else if (in_reg.opcode == OP_READ_EDGE) begin
                    if ({1'b0, in_reg.edge_index} < ecount_reg) begin
                        out_reg.id_out <= {1'b0, erd_reg[14:8]};
                        out_reg.other_id <= erd_reg[7:1];
                        out_reg.alive_out <= erd_reg[0];
                    end
                end
            end
            if (state_reg == S_HITCHK) begin
                if (in_reg.opcode == OP_CLICK || in_reg.opcode == OP_HOVER) begin
                    if (found_reg) begin
                        out_reg.id_out <= {1'b0, best_reg};
                        out_reg.distance_sq <= bestd_reg;
                    end
                    if (in_reg.opcode == OP_HOVER) begin
                        if (!hit) begin
                            out_reg.status <= ST_MISS;
                            if (found_reg) hovv_reg <= 1'b0;
                        end else begin
                            hovv_reg <= 1'b1; hovi_reg <= best_reg;
                        end
                    end else if (!hit) begin
                        out_reg.status <= ST_MISS; selv_reg <= 1'b0;
                    end else if (selv_reg && seli_reg == best_reg) begin
                        selv_reg <= 1'b0;
                    end else if (selv_reg) begin
                        selv_reg <= 1'b0;
                        if (ecount_reg < 9'(MaxEdges)) begin
                            out_reg.status <= ST_EDGE;
                            ecount_reg <= ecount_reg + 9'd1;
                        end else out_reg.status <= ST_FULL;
                    end else begin
                        selv_reg <= 1'b1; seli_reg <= best_reg;
                    end
                end
            end
            if (state_reg == S_ESCAN) begin
                if (scan_reg < ecount_reg) begin
                    e1v_reg <= 1'b1; e1i_reg <= scan_reg[7:0];
                    scan_reg <= scan_reg + 9'd1;
                end
            end
            if (state_reg == S_ERD) begin
                selv_reg <= 1'b0; hovv_reg <= 1'b0;
            end
        end
    end

    // Radius square of the nearest node, from the word read in S_HITRD.
    always_ff @(posedge aclk) begin
        if (state_reg == S_HITRD)
            rsq_reg <= {15'b0, nrd_reg[15:1]} * {15'b0, nrd_reg[15:1]};
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_DISPATCH)
        else $error("accepted transaction not dispatched");
    a_out_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && mv_reg && !m_ready |=> state_reg == S_OUT)
        else $error("result overwritten while stalled");
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        ncount_reg <= 8'(MaxNodes) && ecount_reg <= 9'(MaxEdges))
        else $error("count overflow");
endmodule
